// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the hash table modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hdl/lph_pkg.sv =====
// Types and codes shared by the hash table controller and datapath
`timescale 1ns / 1ps

package lph_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_SRCH
    } t_state;

    typedef struct packed {
        logic    load;
        logic    ins_write;
        logic    advance;
        logic    issue;
        logic    report;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic free_here;
        logic ins_last;
        logic hit;
        logic rd_last;
    } t_stat;

endpackage

// ===== hdl/lph_dpath.sv =====
// Datapath: request registers, slot store, probe pointer and result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lph_dpath #(
    parameter int TABLE_SLOTS = 8,
    parameter int KEY_CHARS   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lph_pkg::t_cmd        i_cmd,
    input  logic [63:0]          i_name_key,
    input  logic [39:0]          i_phone_number,
    output lph_pkg::t_stat       o_stat,
    output logic                 o_done,
    output logic [1:0]           o_status,
    output logic [2:0]           o_slot_index,
    output logic [39:0]          o_found_number
);

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int NAME_W = 8 * KEY_CHARS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

    logic [NAME_W-1:0] mem_name [TABLE_SLOTS];
    logic [39:0]       mem_num  [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_used;

    logic [NAME_W-1:0] r_key;
    logic [39:0]       r_num;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  home;

    logic [NAME_W-1:0] r_rd_name;
    logic [39:0]       r_rd_num;
    logic              r_rd_used;
    logic [IDX_W-1:0]  r_rd_slot;
    logic              r_rd_last;
    logic              r_rd_valid;

    logic              r_done;
    logic [1:0]        r_status;
    logic [2:0]        r_slot;
    logic [39:0]       r_num_out;

    // home slot: first character reduced modulo the table size by shifted subtracts
    always_comb begin
        logic [16:0] rem;
        rem = 17'(i_name_key[7:0]);
        for (int k = 7; k >= 0; k--) begin
            if (rem >= (17'(TABLE_SLOTS) << k)) begin
                rem = rem - (17'(TABLE_SLOTS) << k);
            end
        end
        home = IDX_W'(rem);
    end

    always_comb begin
        n_ptr = r_ptr;
        n_cnt = r_cnt;
        if (i_cmd.load) begin
            n_ptr = home;
            n_cnt = '0;
        end else if (i_cmd.advance || i_cmd.issue) begin
            n_ptr = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_cnt <= n_cnt;
        if (i_cmd.load) begin
            r_key <= i_name_key[NAME_W-1:0];
            r_num <= i_phone_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.ins_write) begin
            r_used[r_ptr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write) begin
            mem_name[r_ptr] <= r_key;
            mem_num[r_ptr]  <= r_num;
        end
    end

    // read one slot a beat; the compare works on the registered read, in the cycle after the pointer named the slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_name <= mem_name[r_ptr];
            r_rd_num  <= mem_num[r_ptr];
            r_rd_used <= r_used[r_ptr];
            r_rd_slot <= r_ptr;
            r_rd_last <= (r_cnt == LAST_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_rd_valid <= 1'b0;
        end else if (i_cmd.issue) begin
            r_rd_valid <= 1'b1;
        end
    end

    always_comb begin
        o_stat.free_here = !r_used[r_ptr];
        o_stat.ins_last  = (r_cnt == LAST_IDX);
        o_stat.hit       = r_rd_valid && r_rd_used && (r_rd_name == r_key);
        o_stat.rd_last   = r_rd_valid && r_rd_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.report) begin
            r_status <= i_cmd.code;
            case (i_cmd.code)
                lph_pkg::ST_INSERTED: begin
                    r_slot    <= 3'(r_ptr);
                    r_num_out <= '0;
                end
                lph_pkg::ST_FOUND: begin
                    r_slot    <= 3'(r_rd_slot);
                    r_num_out <= r_rd_num;
                end
                default: begin
                    r_slot    <= '0;
                    r_num_out <= '0;
                end
            endcase
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_slot_index   = r_slot;
    assign o_found_number = r_num_out;

    `ASSERT_NEVER(a_write_used, i_cmd.ins_write && r_used[r_ptr], "insert overwrote a used slot")
    `ASSERT_CLK(a_done_follows, i_cmd.report |=> r_done, "report without result strobe")
    `ASSERT_CLK(a_num_zero, (r_done && (r_status != lph_pkg::ST_FOUND)) |-> (r_num_out == '0),
        "number given without a match")

endmodule

// ===== hdl/lph_ctrl.sv =====
// Controller: sequences the probe of one request and issues the report
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lph_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_operation,
    input  lph_pkg::t_stat i_stat,
    output lph_pkg::t_cmd  o_cmd,
    output logic           o_busy
);

    lph_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lph_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lph_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = (i_operation == lph_pkg::OP_SEARCH) ? lph_pkg::S_SRCH
                                                                  : lph_pkg::S_INS;
                end
            end
            lph_pkg::S_INS: begin
                if (i_stat.free_here || i_stat.ins_last) begin
                    n_state = lph_pkg::S_IDLE;
                end
            end
            lph_pkg::S_SRCH: begin
                if (i_stat.hit || i_stat.rd_last) begin
                    n_state = lph_pkg::S_IDLE;
                end
            end
            default: n_state = lph_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        o_cmd.code = lph_pkg::ST_INSERTED;
        unique case (r_state)
            lph_pkg::S_IDLE: begin
                o_busy    = 1'b0;
                o_cmd.load = i_start;
            end
            lph_pkg::S_INS: begin
                if (i_stat.free_here) begin
                    o_cmd.ins_write = 1'b1;
                    o_cmd.report    = 1'b1;
                    o_cmd.code      = lph_pkg::ST_INSERTED;
                end else if (i_stat.ins_last) begin
                    o_cmd.report = 1'b1;
                    o_cmd.code   = lph_pkg::ST_FULL;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            lph_pkg::S_SRCH: begin
                // keep reading ahead; extra reads after the decision are dropped
                o_cmd.issue = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.report = 1'b1;
                    o_cmd.code   = lph_pkg::ST_FOUND;
                end else if (i_stat.rd_last) begin
                    o_cmd.report = 1'b1;
                    o_cmd.code   = lph_pkg::ST_MISSING;
                end
            end
            default: o_busy = 1'b1;
        endcase
    end

    `ASSERT_CLK(a_report_busy, o_cmd.report |-> (r_state != lph_pkg::S_IDLE),
        "report while idle")
    `ASSERT_CLK(a_report_ends, o_cmd.report |=> (r_state == lph_pkg::S_IDLE),
        "request kept running after its report")
    `ASSERT_CLK(a_accept_busy, (i_start && !o_busy) |=> o_busy, "accepted beat not held busy")

endmodule

// ===== hdl/linear_probe_hash_table_top.sv =====
// Top level of the linear probing hash table of names and phone numbers
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. An insert probes one
// slot a cycle from the key's home slot (first character modulo TABLE_SLOTS)
// and stays busy until it finds a free slot or has probed all TABLE_SLOTS
// slots; a search reads one slot a cycle from the slot store with a
// registered read and compares it in the next cycle, so it stays busy until
// a match or the compare of the last slot. The single result appears on o_done
// for one cycle, the first cycle with busy low again; it cannot be held off, so
// capture it on the strobe. A new request may be given while that result is
// on the ports. The table is empty after reset with no clearing pass.
module linear_probe_hash_table_top #(
    parameter int TABLE_SLOTS = 8,
    parameter int KEY_CHARS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [63:0] i_name_key,
    input  logic [39:0] i_phone_number,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [2:0]  o_slot_index,
    output logic [39:0] o_found_number
);

    lph_pkg::t_cmd  cmd;
    lph_pkg::t_stat stat;

    lph_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    lph_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KEY_CHARS   (KEY_CHARS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_name_key     (i_name_key),
        .i_phone_number (i_phone_number),
        .o_stat         (stat),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index),
        .o_found_number (o_found_number)
    );

endmodule

// ===== tb/sv/linear_probe_hash_table_top_tb.sv =====
// Testbench for the linear probing hash table: a driver, a monitor and an inline predictor
`timescale 1ns / 1ps

module linear_probe_hash_table_top_tb;

    localparam int TABLE_SLOTS = 8;
    localparam int KEY_CHARS   = 8;
    localparam logic [63:0] KEY_MASK =
        (KEY_CHARS >= 8) ? {64{1'b1}} : ((64'd1 << (8 * KEY_CHARS)) - 64'd1);
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 3 * TABLE_SLOTS;

    typedef struct packed {
        logic        op;
        logic [63:0] key;
        logic [39:0] number;
    } request_t;

    typedef struct packed {
        lph_pkg::t_status status;
        logic [2:0]       slot;
        logic [39:0]      number;
    } outcome_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        i_operation = lph_pkg::OP_INSERT;
    logic [63:0] i_name_key = '0;
    logic [39:0] i_phone_number = '0;
    logic        busy;
    logic        o_done;
    logic [1:0]  o_status;
    logic [2:0]  o_slot_index;
    logic [39:0] o_found_number;

    // Predictor copy of the table
    logic        slot_used [TABLE_SLOTS];
    logic [63:0] slot_key  [TABLE_SLOTS];
    logic [39:0] slot_phone[TABLE_SLOTS];

    request_t    request_q[$];
    outcome_t    outcome_q[$];
    logic [63:0] stored_keys[$];

    logic        beat_taken = 1'b0;
    int unsigned idle_left = 0;
    int unsigned burst_left = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    request_t    next_req;
    outcome_t    got_outcome;
    outcome_t    want_outcome;

    linear_probe_hash_table_top #(
        .TABLE_SLOTS(TABLE_SLOTS),
        .KEY_CHARS  (KEY_CHARS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_name_key    (i_name_key),
        .i_phone_number(i_phone_number),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index),
        .o_found_number(o_found_number)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic outcome_t probe_table(request_t rq);
        outcome_t    res;
        logic [63:0] key;
        int unsigned home;
        int unsigned s;
        key = rq.key & KEY_MASK;
        home = key[7:0] % TABLE_SLOTS;
        res.status = (rq.op == lph_pkg::OP_INSERT) ? lph_pkg::ST_FULL : lph_pkg::ST_MISSING;
        res.slot = '0;
        res.number = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            s = (home + i) % TABLE_SLOTS;
            if (rq.op == lph_pkg::OP_INSERT) begin
                if (!slot_used[s]) begin
                    slot_used[s] = 1'b1;
                    slot_key[s] = key;
                    slot_phone[s] = rq.number;
                    res.status = lph_pkg::ST_INSERTED;
                    res.slot = s[2:0];
                    return res;
                end
            end else if (slot_used[s] && slot_key[s] == key) begin
                res.status = lph_pkg::ST_FOUND;
                res.slot = s[2:0];
                res.number = slot_phone[s];
                return res;
            end
        end
        return res;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with none
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_request(logic op, logic [63:0] key, logic [39:0] number);
        request_t rq;
        rq.op = op;
        rq.key = key;
        rq.number = number;
        request_q.push_back(rq);
        if (op == lph_pkg::OP_INSERT) stored_keys.push_back(key);
    endtask

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        k = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0) k = k & 64'h7F7F_7F7F_7F7F_7F7F;
        return k;
    endfunction

    // Driver: hold a beat until taken, then idle or present the next one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && !beat_taken)) begin
            if (start) idle_left = pick_gap();
            if (idle_left == 0 && request_q.size() != 0) begin
                next_req = request_q.pop_front();
                i_operation <= next_req.op;
                i_name_key <= next_req.key;
                i_phone_number <= next_req.number;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
                if (idle_left != 0) idle_left--;
            end
        end
    end

    // Monitor: check each strobed result, then predict the beat taken at this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
        end else begin
            beat_taken <= start && !busy;
            if (o_done) begin
                got_outcome.status = lph_pkg::t_status'(o_status);
                got_outcome.slot = o_slot_index;
                got_outcome.number = o_found_number;
                if (outcome_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%h",
                             $time, o_status, o_slot_index, o_found_number);
                end else begin
                    want_outcome = outcome_q.pop_front();
                    if (got_outcome.status !== want_outcome.status) begin
                        error_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want_outcome.status, o_status);
                    end
                    if (got_outcome.slot !== want_outcome.slot) begin
                        error_count++;
                        $display("%0t: slot_index expected %0d actual %0d",
                                 $time, want_outcome.slot, o_slot_index);
                    end
                    if (got_outcome.number !== want_outcome.number) begin
                        error_count++;
                        $display("%0t: found_number expected %h actual %h",
                                 $time, want_outcome.number, o_found_number);
                    end
                end
            end
            if (start && !busy) begin
                outcome_q.push_back(probe_table({i_operation, i_name_key, i_phone_number}));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [63:0] k;
        int unsigned pick;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_key[i] = '0;
            slot_phone[i] = '0;
        end

        // Empty table, duplicates, wrap-around, zero key, high bytes, full table
        add_request(lph_pkg::OP_SEARCH, 64'h41, 40'hFF_FFFF_FFFF);
        add_request(lph_pkg::OP_INSERT, 64'h41, 40'h0);
        add_request(lph_pkg::OP_INSERT, 64'h41, 40'hFF_FFFF_FFFF);
        add_request(lph_pkg::OP_SEARCH, 64'h41, 40'h0);
        add_request(lph_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 40'h55_5555_5555);
        add_request(lph_pkg::OP_INSERT, 64'h8000_0000_0000_000F, 40'hAA_AAAA_AAAA);
        add_request(lph_pkg::OP_INSERT, 64'h0, 40'h12_3456_789A);
        add_request(lph_pkg::OP_INSERT, 64'h0000_0042_0000_0043, 40'h00_0000_0001);
        add_request(lph_pkg::OP_SEARCH, 64'h0000_0042_0000_0043, 40'h0);
        add_request(lph_pkg::OP_SEARCH, 64'h0000_0000_0000_0043, 40'h0);
        add_request(lph_pkg::OP_SEARCH, 64'h0, 40'hAA_AAAA_AAAA);
        add_request(lph_pkg::OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 40'h0);
        add_request(lph_pkg::OP_SEARCH, 64'h8000_0000_0000_000F, 40'h0);
        add_request(lph_pkg::OP_SEARCH, 64'h0000_0000_0000_0016, 40'h0);
        add_request(lph_pkg::OP_INSERT, 64'h7FFF_FFFF_FFFF_FFF8, 40'h80_0000_0000);
        add_request(lph_pkg::OP_INSERT, 64'h0102_0304_0506_0708, 40'h7F_FFFF_FFFF);
        add_request(lph_pkg::OP_INSERT, 64'h0102_0304_0506_0709, 40'hFF_FFFF_FFFF);
        add_request(lph_pkg::OP_SEARCH, 64'h0102_0304_0506_0709, 40'h0);
        add_request(lph_pkg::OP_SEARCH, 64'h0102_0304_0506_0708, 40'h0);
        add_request(lph_pkg::OP_SEARCH, 64'h7FFF_FFFF_FFFF_FFF8, 40'h0);
        add_request(lph_pkg::OP_SEARCH, 64'h41, 40'h55_5555_5555);

        // Mostly lookups of stored names, with near misses, noise and inserts
        for (int n = 0; n < 1050; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                k = ($urandom_range(0, 1) == 0) ? random_key()
                    : stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                add_request(lph_pkg::OP_INSERT, k, 40'({$urandom, $urandom}));
            end else if (pick < 68) begin
                k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                add_request(lph_pkg::OP_SEARCH, k, 40'({$urandom, $urandom}));
            end else if (pick < 84) begin
                k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                k[$urandom_range(0, 63)] ^= 1'b1;
                add_request(lph_pkg::OP_SEARCH, k, 40'({$urandom, $urandom}));
            end else begin
                add_request(lph_pkg::OP_SEARCH, random_key(), 40'({$urandom, $urandom}));
            end
        end

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || start || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && outcome_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
